### rtl/bba_pkg.sv
// Shared types, constants and helpers of the buddy block allocator.
package bba_pkg;

    localparam int LEAF_COUNT  = 256;
    localparam int MAX_ORDER   = 24;
    localparam int LEAF_LOG2   = $clog2(LEAF_COUNT);
    localparam int UNIT_W      = LEAF_LOG2;
    localparam int UCNT_W      = LEAF_LOG2 + 1;
    localparam int ORD_W       = 5;
    localparam int ADDR_W      = 24;
    localparam int SIZE_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREE_REJECT = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_ORDER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_ORDER   = 1'd1;

    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic             start;
        logic             alloc;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [ORD_W-1:0] eff_top;
        logic [ORD_W-1:0] eff_min;
    } cfg_t;

    // Smallest r with 2^r >= size, for size >= 1.
    function automatic logic [5:0] ceil_log2(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] v;
        logic [5:0]        r;
        v = size - SIZE_W'(1);
        r = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                r = 6'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

### rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: config registers, block table, sequencer.
//
//  channel  dir  handshake         payload
//  s_       in   s_valid/s_ready   s_action, s_request_size, s_block_address
//  m_       out  m_valid/m_ready   m_status, m_granted_address, m_granted_order
//  cfg_     in   cfg_we            cfg_index, cfg_data
//
// Allocate scans units = 2^(T-M) entries, read one per cycle from the single read port
// of the table RAM, then splits; a zero or too large size is answered without a scan.
// Free rejects a bad address, or an entry not a live block start, else merges buddies.
// After reset and after every config write the table is cleared; s_ready stays low
// meanwhile. A new request is taken while a result waits on m_.
module buddy_block_allocator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [bba_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [bba_pkg::SIZE_W-1:0]         s_request_size,
    input  logic [bba_pkg::ADDR_W-1:0]         s_block_address,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bba_pkg::STATUS_W-1:0]       m_status,
    output logic [bba_pkg::ADDR_W-1:0]         m_granted_address,
    output logic [bba_pkg::ORD_W-1:0]          m_granted_order
);

    logic [bba_pkg::ORD_W-1:0] total_reg, total_next;
    logic [bba_pkg::ORD_W-1:0] min_reg, min_next;
    logic [bba_pkg::ORD_W-1:0] t_eff, m_eff;
    bba_pkg::cfg_t             cfg;
    logic                      restart;

    logic                        ram_we;
    logic [bba_pkg::UNIT_W-1:0]  ram_waddr, ram_raddr;
    bba_pkg::entry_t             ram_wdata, ram_rdata;
    logic [bba_pkg::ENTRY_W-1:0] ram_rbits;

    always_comb begin
        total_next = total_reg;
        min_next   = min_reg;
        restart    = 1'b0;
        if (cfg_we) begin
            case (cfg_index)
                bba_pkg::REG_TOTAL_ORDER: begin
                    total_next = cfg_data;
                    restart    = 1'b1;
                end
                bba_pkg::REG_MIN_ORDER: begin
                    min_next = cfg_data;
                    restart  = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= bba_pkg::ORD_W'(8);
            min_reg   <= bba_pkg::ORD_W'(2);
        end else begin
            total_reg <= total_next;
            min_reg   <= min_next;
        end
    end

    // raise the floor so the heap fits in the table, cap at the top order
    always_comb begin
        t_eff = (total_reg > bba_pkg::ORD_W'(bba_pkg::MAX_ORDER)) ?
                bba_pkg::ORD_W'(bba_pkg::MAX_ORDER) : total_reg;
        m_eff = min_reg;
        if (t_eff > bba_pkg::ORD_W'(bba_pkg::LEAF_LOG2) &&
            m_eff < t_eff - bba_pkg::ORD_W'(bba_pkg::LEAF_LOG2)) begin
            m_eff = t_eff - bba_pkg::ORD_W'(bba_pkg::LEAF_LOG2);
        end
        if (m_eff > t_eff) begin
            m_eff = t_eff;
        end
    end

    assign cfg.eff_top = t_eff;
    assign cfg.eff_min = m_eff;
    assign ram_rdata   = bba_pkg::entry_t'(ram_rbits);

    bba_ram #(
        .WIDTH(bba_pkg::ENTRY_W),
        .DEPTH(bba_pkg::LEAF_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    bba_engine u_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .restart           (restart),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_request_size    (s_request_size),
        .s_block_address   (s_block_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address),
        .m_granted_order   (m_granted_order),
        .ram_we            (ram_we),
        .ram_waddr         (ram_waddr),
        .ram_wdata         (ram_wdata),
        .ram_raddr         (ram_raddr),
        .ram_rdata         (ram_rdata)
    );

endmodule

### rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/bba_engine.sv
// Sequencer: table clear, allocate scan and split, free check and merge.
module bba_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bba_pkg::cfg_t                   cfg,
    input  logic                            restart,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [bba_pkg::SIZE_W-1:0]      s_request_size,
    input  logic [bba_pkg::ADDR_W-1:0]      s_block_address,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bba_pkg::STATUS_W-1:0]    m_status,
    output logic [bba_pkg::ADDR_W-1:0]      m_granted_address,
    output logic [bba_pkg::ORD_W-1:0]       m_granted_order,
    output logic                            ram_we,
    output logic [bba_pkg::UNIT_W-1:0]      ram_waddr,
    output bba_pkg::entry_t                 ram_wdata,
    output logic [bba_pkg::UNIT_W-1:0]      ram_raddr,
    input  bba_pkg::entry_t                 ram_rdata
);

    typedef enum logic [10:0] {
        ST_CLEAR   = 11'b00000000001,
        ST_IDLE    = 11'b00000000010,
        ST_PREP    = 11'b00000000100,
        ST_A_SCAN  = 11'b00000001000,
        ST_A_SPLIT = 11'b00000010000,
        ST_A_FINAL = 11'b00000100000,
        ST_F_CHECK = 11'b00001000000,
        ST_M_READ  = 11'b00010000000,
        ST_M_CHECK = 11'b00100000000,
        ST_M_WLO   = 11'b01000000000,
        ST_DONE    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [bba_pkg::UNIT_W-1:0]   clr_reg, clr_next;
    logic                         act_reg, act_next;
    logic [5:0]                   req_reg, req_next;
    logic                         zero_reg, zero_next;
    logic [bba_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [bba_pkg::UCNT_W-1:0]   scan_reg, scan_next;
    logic                         pend_reg, pend_next;
    logic [bba_pkg::UNIT_W-1:0]   pend_u_reg, pend_u_next;
    logic                         found_reg, found_next;
    logic [bba_pkg::UNIT_W-1:0]   u_reg, u_next;
    logic [bba_pkg::ORD_W-1:0]    ord_reg, ord_next;
    logic [bba_pkg::STATUS_W-1:0] res_st_reg, res_st_next;
    logic [bba_pkg::ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [bba_pkg::ORD_W-1:0]    res_ord_reg, res_ord_next;
    logic                         m_valid_reg, m_valid_next;
    logic [bba_pkg::STATUS_W-1:0] m_st_reg, m_st_next;
    logic [bba_pkg::ADDR_W-1:0]   m_addr_reg, m_addr_next;
    logic [bba_pkg::ORD_W-1:0]    m_ord_reg, m_ord_next;

    logic [bba_pkg::ORD_W-1:0]  tt, mm, o_dec, span;
    logic [bba_pkg::UCNT_W-1:0] units;
    logic [bba_pkg::UNIT_W-1:0] half_off, bud_bit, bud;
    logic [bba_pkg::ADDR_W-1:0] mask;
    logic [5:0]                 r_raw;
    logic                       accept;

    assign tt     = cfg.eff_top;
    assign mm     = cfg.eff_min;
    assign units  = bba_pkg::UCNT_W'(1) << (tt - mm);
    assign o_dec  = ord_reg - bba_pkg::ORD_W'(1);
    assign span   = ord_reg - mm;
    assign half_off = bba_pkg::UNIT_W'(bba_pkg::UCNT_W'(1) << (o_dec - mm));
    assign bud_bit  = bba_pkg::UNIT_W'(bba_pkg::UCNT_W'(1) << span);
    assign bud    = u_reg ^ bud_bit;
    assign mask   = ~({bba_pkg::ADDR_W{1'b1}} << mm);
    assign r_raw  = bba_pkg::ceil_log2(s_request_size);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        act_next      = act_reg;
        req_next      = req_reg;
        zero_next     = zero_reg;
        addr_next     = addr_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_u_next   = pend_u_reg;
        found_next    = found_reg;
        u_next        = u_reg;
        ord_next      = ord_reg;
        res_st_next   = res_st_reg;
        res_addr_next = res_addr_reg;
        res_ord_next  = res_ord_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_st_next     = m_st_reg;
        m_addr_next   = m_addr_reg;
        m_ord_next    = m_ord_reg;
        ram_we        = 1'b0;
        ram_waddr     = u_reg;
        ram_wdata     = '0;
        ram_raddr     = u_reg;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == '0) begin
                    ram_wdata = '{order: tt, start: 1'b1, alloc: 1'b0};
                end
                clr_next = clr_reg + bba_pkg::UNIT_W'(1);
                if (clr_reg == {bba_pkg::UNIT_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    act_next   = s_action;
                    zero_next  = (s_request_size == '0);
                    req_next   = (r_raw < 6'(mm)) ? 6'(mm) : r_raw;
                    addr_next  = s_block_address;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                res_addr_next = '0;
                res_ord_next  = '0;
                if (act_reg == bba_pkg::ACT_ALLOC) begin
                    if (zero_reg || req_reg > 6'(tt)) begin
                        res_st_next = bba_pkg::STATUS_NO_SPACE;
                        state_next  = ST_DONE;
                    end else begin
                        scan_next  = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                        state_next = ST_A_SCAN;
                    end
                end else begin
                    if (((addr_reg >> tt) != '0) || ((addr_reg & mask) != '0)) begin
                        res_st_next = bba_pkg::STATUS_FREE_REJECT;
                        state_next  = ST_DONE;
                    end else begin
                        u_next     = bba_pkg::UNIT_W'(addr_reg >> mm);
                        ram_raddr  = bba_pkg::UNIT_W'(addr_reg >> mm);
                        state_next = ST_F_CHECK;
                    end
                end
            end
            ST_A_SCAN: begin
                if (scan_reg < units) begin
                    ram_raddr   = bba_pkg::UNIT_W'(scan_reg);
                    pend_u_next = bba_pkg::UNIT_W'(scan_reg);
                    pend_next   = 1'b1;
                    scan_next   = scan_reg + bba_pkg::UCNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
                // keep the smallest fitting order, first address on ties
                if (pend_reg && ram_rdata.start && !ram_rdata.alloc &&
                    6'(ram_rdata.order) >= req_reg &&
                    (!found_reg || ram_rdata.order < ord_reg)) begin
                    found_next = 1'b1;
                    u_next     = pend_u_reg;
                    ord_next   = ram_rdata.order;
                end
                if (scan_reg == units && !pend_reg) begin
                    if (!found_reg) begin
                        res_st_next = bba_pkg::STATUS_NO_SPACE;
                        state_next  = ST_DONE;
                    end else if (6'(ord_reg) > req_reg) begin
                        state_next = ST_A_SPLIT;
                    end else begin
                        state_next = ST_A_FINAL;
                    end
                end
            end
            ST_A_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = u_reg + half_off;
                ram_wdata = '{order: o_dec, start: 1'b1, alloc: 1'b0};
                ord_next  = o_dec;
                if (6'(o_dec) == req_reg) begin
                    state_next = ST_A_FINAL;
                end
            end
            ST_A_FINAL: begin
                ram_we        = 1'b1;
                ram_waddr     = u_reg;
                ram_wdata     = '{order: bba_pkg::ORD_W'(req_reg), start: 1'b1, alloc: 1'b1};
                res_st_next   = bba_pkg::STATUS_OK;
                res_addr_next = bba_pkg::ADDR_W'(bba_pkg::ADDR_W'(u_reg) << mm);
                res_ord_next  = bba_pkg::ORD_W'(req_reg);
                state_next    = ST_DONE;
            end
            ST_F_CHECK: begin
                if (!(ram_rdata.start && ram_rdata.alloc)) begin
                    res_st_next = bba_pkg::STATUS_FREE_REJECT;
                    state_next  = ST_DONE;
                end else begin
                    ram_we      = 1'b1;
                    ram_waddr   = u_reg;
                    ram_wdata   = '{order: ram_rdata.order, start: 1'b1, alloc: 1'b0};
                    ord_next    = ram_rdata.order;
                    res_st_next = bba_pkg::STATUS_OK;
                    state_next  = ST_M_READ;
                end
            end
            ST_M_READ: begin
                if (ord_reg < tt && ord_reg >= mm) begin
                    ram_raddr  = bud;
                    state_next = ST_M_CHECK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_M_CHECK: begin
                if (ram_rdata.start && !ram_rdata.alloc && ram_rdata.order == ord_reg) begin
                    // drop the upper half, grow the lower one next
                    ram_we     = 1'b1;
                    ram_waddr  = (bud > u_reg) ? bud : u_reg;
                    u_next     = (bud < u_reg) ? bud : u_reg;
                    state_next = ST_M_WLO;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_M_WLO: begin
                ram_we     = 1'b1;
                ram_waddr  = u_reg;
                ram_wdata  = '{order: ord_reg + bba_pkg::ORD_W'(1), start: 1'b1, alloc: 1'b0};
                ord_next   = ord_reg + bba_pkg::ORD_W'(1);
                state_next = ST_M_READ;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_st_next    = res_st_reg;
                    m_addr_next  = res_addr_reg;
                    m_ord_next   = res_ord_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        if (restart) begin
            state_next = ST_CLEAR;
            clr_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg      <= act_next;
        req_reg      <= req_next;
        zero_reg     <= zero_next;
        addr_reg     <= addr_next;
        scan_reg     <= scan_next;
        pend_reg     <= pend_next;
        pend_u_reg   <= pend_u_next;
        found_reg    <= found_next;
        u_reg        <= u_next;
        ord_reg      <= ord_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        res_ord_reg  <= res_ord_next;
        m_st_reg     <= m_st_next;
        m_addr_reg   <= m_addr_next;
        m_ord_reg    <= m_ord_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_st_reg;
    assign m_granted_address = m_addr_reg;
    assign m_granted_order   = m_ord_reg;

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("table written while idle");

    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !restart) |=> (state_reg == ST_PREP))
        else $error("accepted request not started");

    a_split_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_A_SPLIT) |-> (6'(ord_reg) > req_reg))
        else $error("split below requested order");

    a_final_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_A_FINAL) |-> (6'(ord_reg) == req_reg))
        else $error("grant order mismatch");

endmodule
